// ===== hdl/bez_pkg.sv =====
// Shared types and constants for the Bezier easing table entry core.
// Used by bez_mul, bez_div and bezier_easing_table_entry_core; depends on nothing.
`default_nettype none
package bez_pkg;

   localparam int VAL_W  = 40;
   localparam int T_W    = 32;
   localparam int FRAC_W = 30;
   localparam int DIV_W  = VAL_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int CFG_W  = 17;
   localparam int SIZE_W = 13;
   localparam int OUT_W  = 18;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [T_W-1:0] tval_type;

   localparam val_type ONE_Q30   = val_type'(64'sd1073741824);
   localparam val_type RESID_LIM = val_type'(64'sd107374);
   localparam val_type SLOPE_LIM = val_type'(64'sd1074);

   localparam logic [CSR_IDX_W-1:0] CSR_X1   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X2   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 3'd4;

   localparam logic [1:0] REASON_CONV  = 2'd0;
   localparam logic [1:0] REASON_SLOPE = 2'd1;
   localparam logic [1:0] REASON_CAP   = 2'd2;

   typedef struct packed {
      logic     go;
      val_type  a;
      tval_type b;
   } mul_req_type;

   typedef struct packed {
      logic             go;
      logic [VAL_W-1:0] num;
      logic [VAL_W-1:0] den;
   } div_req_type;

endpackage
`default_nettype wire

// ===== hdl/bez_mul.sv =====
// Multi-cycle signed Q30 multiplier: a * t / 2^30, truncated toward zero.
// Uses two 40x16 partial products; depends on bez_pkg.
`default_nettype none
module bez_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bez_pkg::mul_req_type req,
   output logic                     done,
   output bez_pkg::val_type         result
);

   typedef enum logic [4:0] {
      M_IDLE = 5'b00001,
      M_LO   = 5'b00010,
      M_HI   = 5'b00100,
      M_SUM  = 5'b01000,
      M_DONE = 5'b10000
   } mstate_type;

   localparam int PP_W   = bez_pkg::VAL_W + 16;
   localparam int PROD_W = bez_pkg::VAL_W + bez_pkg::T_W;

   mstate_type                   state_ff, state_in;
   logic [bez_pkg::VAL_W-1:0]    ua_ff, ua_in;
   logic [bez_pkg::T_W-1:0]      ub_ff, ub_in;
   logic                         neg_ff, neg_in;
   logic [PP_W-1:0]              pp_ff, pp_in;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic [bez_pkg::VAL_W-1:0]    mag;

   always_comb begin
      state_in = state_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      neg_in   = neg_ff;
      pp_in    = pp_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (req.go) begin
               ua_in    = req.a[bez_pkg::VAL_W-1] ? bez_pkg::VAL_W'(-req.a) : req.a;
               ub_in    = req.b[bez_pkg::T_W-1] ? bez_pkg::T_W'(-req.b) : req.b;
               neg_in   = req.a[bez_pkg::VAL_W-1] ^ req.b[bez_pkg::T_W-1];
               state_in = M_LO;
            end
         end
         M_LO: begin
            pp_in    = ua_ff * ub_ff[15:0];
            state_in = M_HI;
         end
         M_HI: begin
            prod_in  = PROD_W'(pp_ff);
            pp_in    = ua_ff * ub_ff[31:16];
            state_in = M_SUM;
         end
         M_SUM: begin
            prod_in  = prod_ff + {pp_ff, 16'd0};
            state_in = M_DONE;
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   assign mag    = prod_ff[bez_pkg::FRAC_W +: bez_pkg::VAL_W];
   assign done   = (state_ff == M_DONE);
   assign result = neg_ff ? bez_pkg::val_type'(-mag) : bez_pkg::val_type'(mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      pp_ff   <= pp_in;
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

// ===== hdl/bez_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(num * 2^30 / den).
// Depends on bez_pkg.
`default_nettype none
module bez_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bez_pkg::div_req_type req,
   output logic                      done,
   output logic [bez_pkg::DIV_W-1:0] quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [bez_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [bez_pkg::DIV_W-1:0]        qd_ff, qd_in;
   logic [bez_pkg::VAL_W-1:0]        rem_ff, rem_in;
   logic [bez_pkg::VAL_W-1:0]        den_ff, den_in;
   logic [bez_pkg::VAL_W:0]          sh;
   logic                             ge;

   assign sh = {rem_ff, qd_ff[bez_pkg::DIV_W-1]};
   assign ge = (sh >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      qd_in   = qd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         qd_in   = {req.num, {bez_pkg::FRAC_W{1'b0}}};
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? bez_pkg::VAL_W'(sh - {1'b0, den_ff}) : sh[bez_pkg::VAL_W-1:0];
         qd_in  = {qd_ff[bez_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bez_pkg::DIV_CNT_W'(bez_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = qd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule
`default_nettype wire

// ===== hdl/bezier_easing_table_entry_core.sv =====
// Top level of the Bezier easing table entry core: sequencer, registers and ports.
// Depends on bez_pkg, bez_mul and bez_div.
// One word at a time: x = index / size runs on the divider. Each Newton step evaluates
// the curve and the slope on the shared multiplier (5 products plus two checks); a step
// that does not stop then runs one division. A word that converges, or stops on a flat
// slope or at the iteration cap, ends by evaluating y on the same multiplier. Indexes at
// or above the table size skip the solve and answer 1.0 from the check state.
`default_nettype none
module bezier_easing_table_entry_core #(
   parameter int MAX_ITERATIONS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [bez_pkg::SIZE_W-1:0]      req_entry_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic signed [bez_pkg::OUT_W-1:0]     rsp_eased_value,
   output logic [1:0]                           rsp_stop_reason,
   input  wire logic                            csr_wen,
   input  wire logic [bez_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bez_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int N_W = $clog2(MAX_ITERATIONS + 1);
   localparam int VW  = bez_pkg::VAL_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_XDIV = 5'b00010,
      S_MUL  = 5'b00100,
      S_CHK  = 5'b01000,
      S_NDIV = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      K_CX = 2'd0,
      K_SX = 2'd1,
      K_CY = 2'd2
   } kind_type;

   state_type                       state_ff, state_in;
   kind_type                        kind_ff, kind_in;
   logic [1:0]                      ph_ff, ph_in;
   bez_pkg::val_type                acc_ff, acc_in;
   bez_pkg::val_type                v_ff, v_in;
   logic [bez_pkg::FRAC_W-1:0]      x_ff, x_in;
   bez_pkg::tval_type               t_ff, t_in;
   logic [N_W-1:0]                  n_ff, n_in;
   logic [1:0]                      reason_ff, reason_in;
   logic                            div_neg_ff, div_neg_in;
   logic                            mul_go_ff, mul_go_in;
   bez_pkg::div_req_type            div_req_ff, div_req_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [bez_pkg::OUT_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                      rsp_reason_ff, rsp_reason_in;

   logic [bez_pkg::CFG_W-1:0]       x1_ff, x2_ff, y1_ff, y2_ff;
   logic [bez_pkg::SIZE_W-1:0]      size_ff;

   bez_pkg::mul_req_type            mul_req;
   logic                            mul_done;
   bez_pkg::val_type                mul_res;
   logic                            div_done;
   logic [bez_pkg::DIV_W-1:0]       div_quo;

   bez_pkg::val_type px1, px2, py1, py2;
   bez_pkg::val_type cx_a, cx_b, cx_c, sx_a, sx_b, cy_a, cy_b, cy_c;
   bez_pkg::val_type term, sum, vres, vmag, smag, ymag_full;
   logic             last;
   logic [VW-15:0]   ymag;
   logic             big;
   logic signed [35:0] tw, qe, tn;
   bez_pkg::tval_type tsat;

   assign px1 = VW'({x1_ff, 14'd0});
   assign px2 = VW'({x2_ff, 14'd0});
   assign py1 = VW'({y1_ff, 14'd0});
   assign py2 = VW'({y2_ff, 14'd0});

   assign cx_c = px1 + (px1 <<< 1);
   assign cx_a = bez_pkg::ONE_Q30 + cx_c - (px2 + (px2 <<< 1));
   assign cx_b = (px2 + (px2 <<< 1)) - (cx_c <<< 1);
   assign sx_a = cx_a + (cx_a <<< 1);
   assign sx_b = cx_b <<< 1;
   assign cy_c = py1 + (py1 <<< 1);
   assign cy_a = bez_pkg::ONE_Q30 + cy_c - (py2 + (py2 <<< 1));
   assign cy_b = (py2 + (py2 <<< 1)) - (cy_c <<< 1);

   always_comb begin
      term = '0;
      last = 1'b0;
      case (kind_ff)
         K_SX: begin
            term = (ph_ff == 2'd0) ? sx_b : cx_c;
            last = (ph_ff == 2'd1);
         end
         K_CY: begin
            term = (ph_ff == 2'd0) ? cy_b : ((ph_ff == 2'd1) ? cy_c : '0);
            last = (ph_ff == 2'd2);
         end
         default: begin
            term = (ph_ff == 2'd0) ? cx_b : ((ph_ff == 2'd1) ? cx_c : '0);
            last = (ph_ff == 2'd2);
         end
      endcase
   end

   assign sum       = mul_res + term;
   assign vres      = acc_ff - VW'({1'b0, x_ff});
   assign vmag      = vres[VW-1] ? VW'(-vres) : vres;
   assign smag      = acc_ff[VW-1] ? VW'(-acc_ff) : acc_ff;
   assign ymag_full = smag;
   assign ymag      = ymag_full[VW-1:14];

   assign big = |div_quo[bez_pkg::DIV_W-1:34];
   assign tw  = 36'(t_ff);
   assign qe  = {2'b00, div_quo[33:0]};
   assign tn  = div_neg_ff ? (tw + qe) : (tw - qe);

   always_comb begin
      if (big) begin
         tsat = div_neg_ff ? 32'sh7FFFFFFF : 32'sh80000000;
      end else if (tn > 36'sh07FFFFFFF) begin
         tsat = 32'sh7FFFFFFF;
      end else if (tn < -36'sh080000000) begin
         tsat = 32'sh80000000;
      end else begin
         tsat = tn[31:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      ph_in         = ph_ff;
      acc_in        = acc_ff;
      v_in          = v_ff;
      x_in          = x_ff;
      t_in          = t_ff;
      n_in          = n_ff;
      reason_in     = reason_ff;
      div_neg_in    = div_neg_ff;
      mul_go_in     = 1'b0;
      div_req_in    = div_req_ff;
      div_req_in.go = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_reason_in = rsp_reason_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_entry_index >= size_ff) begin
                  acc_in    = bez_pkg::ONE_Q30;
                  kind_in   = K_CY;
                  reason_in = bez_pkg::REASON_CONV;
                  state_in  = S_CHK;
               end else begin
                  div_req_in.go  = 1'b1;
                  div_req_in.num = VW'(req_entry_index);
                  div_req_in.den = VW'(size_ff);
                  state_in       = S_XDIV;
               end
            end
         end
         S_XDIV: begin
            if (div_done) begin
               x_in      = div_quo[bez_pkg::FRAC_W-1:0];
               t_in      = bez_pkg::T_W'(div_quo[bez_pkg::FRAC_W-1:0]);
               n_in      = '0;
               kind_in   = K_CX;
               acc_in    = cx_a;
               ph_in     = 2'd0;
               mul_go_in = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               acc_in = sum;
               if (last) begin
                  state_in = S_CHK;
               end else begin
                  ph_in     = ph_ff + 2'd1;
                  mul_go_in = 1'b1;
               end
            end
         end
         S_CHK: begin
            case (kind_ff)
               K_CX: begin
                  ph_in     = 2'd0;
                  mul_go_in = 1'b1;
                  state_in  = S_MUL;
                  if (vmag <= bez_pkg::RESID_LIM) begin
                     reason_in = bez_pkg::REASON_CONV;
                     kind_in   = K_CY;
                     acc_in    = cy_a;
                  end else begin
                     v_in    = vres;
                     kind_in = K_SX;
                     acc_in  = sx_a;
                  end
               end
               K_SX: begin
                  if (smag < bez_pkg::SLOPE_LIM || n_ff >= N_W'(MAX_ITERATIONS)) begin
                     reason_in = (smag < bez_pkg::SLOPE_LIM) ? bez_pkg::REASON_SLOPE
                                                             : bez_pkg::REASON_CAP;
                     kind_in   = K_CY;
                     acc_in    = cy_a;
                     ph_in     = 2'd0;
                     mul_go_in = 1'b1;
                     state_in  = S_MUL;
                  end else begin
                     div_req_in.go  = 1'b1;
                     div_req_in.num = v_ff[VW-1] ? VW'(-v_ff) : v_ff;
                     div_req_in.den = smag;
                     div_neg_in     = v_ff[VW-1] ^ acc_ff[VW-1];
                     state_in       = S_NDIV;
                  end
               end
               default: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_in  = 1'b1;
                     rsp_reason_in = reason_ff;
                     if (acc_ff[VW-1]) begin
                        rsp_value_in = (ymag > (VW-14)'(131072)) ? 18'sh20000
                                                                 : -$signed(ymag[17:0]);
                     end else begin
                        rsp_value_in = (ymag > (VW-14)'(131071)) ? 18'sh1FFFF
                                                                 : $signed(ymag[17:0]);
                     end
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_NDIV: begin
            if (div_done) begin
               t_in      = tsat;
               n_in      = n_ff + 1'b1;
               kind_in   = K_CX;
               acc_in    = cx_a;
               ph_in     = 2'd0;
               mul_go_in = 1'b1;
               state_in  = S_MUL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign mul_req.go = mul_go_ff;
   assign mul_req.a  = acc_ff;
   assign mul_req.b  = t_ff;

   bez_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_res)
   );

   bez_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_eased_value = rsp_value_ff;
   assign rsp_stop_reason = rsp_reason_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mul_go_ff     <= 1'b0;
         div_req_ff.go <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         x1_ff         <= bez_pkg::CFG_W'(16384);
         x2_ff         <= bez_pkg::CFG_W'(49152);
         y1_ff         <= bez_pkg::CFG_W'(16384);
         y2_ff         <= bez_pkg::CFG_W'(49152);
         size_ff       <= bez_pkg::SIZE_W'(256);
      end else begin
         state_ff      <= state_in;
         mul_go_ff     <= mul_go_in;
         div_req_ff.go <= div_req_in.go;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index)
               bez_pkg::CSR_X1:   x1_ff   <= csr_wdata;
               bez_pkg::CSR_X2:   x2_ff   <= csr_wdata;
               bez_pkg::CSR_Y1:   y1_ff   <= csr_wdata;
               bez_pkg::CSR_Y2:   y2_ff   <= csr_wdata;
               bez_pkg::CSR_SIZE: size_ff <= csr_wdata[bez_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
      end
      kind_ff         <= kind_in;
      ph_ff           <= ph_in;
      acc_ff          <= acc_in;
      v_ff            <= v_in;
      x_ff            <= x_in;
      t_ff            <= t_in;
      n_ff            <= n_in;
      reason_ff       <= reason_in;
      div_neg_ff      <= div_neg_in;
      div_req_ff.num  <= div_req_in.num;
      div_req_ff.den  <= div_req_in.den;
      rsp_value_ff    <= rsp_value_in;
      rsp_reason_ff   <= rsp_reason_in;
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for bezier_easing_table_entry_core: drives table indexes under several
// curve settings and checks each word against a built-in Newton-solve predictor or a
// directed expected value. Depends on bez_pkg and bezier_easing_table_entry_core.
`timescale 1ns / 100ps
module tb;

   localparam int MAX_ITER = 16;
   localparam int LIMIT = 8000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [bez_pkg::SIZE_W-1:0] req_entry_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [bez_pkg::OUT_W-1:0] rsp_eased_value;
   logic [1:0] rsp_stop_reason;
   logic csr_wen = 1'b0;
   logic [bez_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bez_pkg::CFG_W-1:0] csr_wdata = '0;

   bezier_easing_table_entry_core #(.MAX_ITERATIONS(MAX_ITER)) uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct packed {
      logic signed [bez_pkg::OUT_W-1:0] eased;
      logic [1:0] reason;
   } entry_result_type;

   entry_result_type pending_entries[$];
   logic [16:0] cx1, cx2, cy1, cy2;
   logic [12:0] tsize;
   int errors = 0;
   int cycles = 0;
   logic rsp_stalls = 1'b1;

   function automatic logic [63:0] mag64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      logic [63:0] ua, ub, hi, lo, r;
      ua = mag64(a);
      ub = mag64(b);
      hi = ub >> 15;
      lo = ub & 64'h7fff;
      r = (ua * hi + ((ua * lo) >> 15)) >> 15;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint div_q30(longint v, longint s);
      logic [63:0] num, den, q, r;
      num = mag64(v);
      den = mag64(s);
      q = num / den;
      r = num % den;
      for (int k = 0; k < 30; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return ((v < 0) != (s < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint bez_curve(longint t, logic [16:0] p1, logic [16:0] p2);
      longint a, b, c, acc;
      a = (longint'(1) << 30) + 3 * (longint'(p1) << 14) - 3 * (longint'(p2) << 14);
      b = 3 * (longint'(p2) << 14) - 6 * (longint'(p1) << 14);
      c = 3 * (longint'(p1) << 14);
      acc = mul_q30(a, t) + b;
      acc = mul_q30(acc, t) + c;
      return mul_q30(acc, t);
   endfunction

   function automatic longint bez_slope(longint t, logic [16:0] p1, logic [16:0] p2);
      longint a, b, c;
      a = 3 * (longint'(1) << 30) + 9 * (longint'(p1) << 14) - 9 * (longint'(p2) << 14);
      b = 6 * (longint'(p2) << 14) - 12 * (longint'(p1) << 14);
      c = 3 * (longint'(p1) << 14);
      return mul_q30(mul_q30(a, t) + b, t) + c;
   endfunction

   function automatic entry_result_type solve_entry(logic [12:0] idx);
      entry_result_type res;
      longint x, t, v, s, y;
      logic [63:0] m;
      if (idx >= tsize) begin
         res.eased = 18'sd65536;
         res.reason = bez_pkg::REASON_CONV;
         return res;
      end
      res.reason = bez_pkg::REASON_CAP;
      x = longint'((64'(idx) << 30) / 64'(tsize));
      t = x;
      for (int n = 0; n <= MAX_ITER; n++) begin
         v = bez_curve(t, cx1, cx2) - x;
         if (mag64(v) <= 107374) begin
            res.reason = bez_pkg::REASON_CONV;
            break;
         end
         s = bez_slope(t, cx1, cx2);
         if (mag64(s) < 1074) begin
            res.reason = bez_pkg::REASON_SLOPE;
            break;
         end
         if (n >= MAX_ITER) begin
            res.reason = bez_pkg::REASON_CAP;
            break;
         end
         t = t - div_q30(v, s);
         if (t > 64'sd2147483647) t = 64'sd2147483647;
         if (t < -64'sd2147483648) t = -64'sd2147483648;
      end
      y = bez_curve(t, cy1, cy2);
      m = mag64(y) >> 14;
      if (y < 0) y = (m > 131072) ? -131072 : -longint'(m);
      else y = (m > 131071) ? 131071 : longint'(m);
      res.eased = y[bez_pkg::OUT_W-1:0];
      return res;
   endfunction

   task automatic write_csr(logic [bez_pkg::CSR_IDX_W-1:0] idx,
                            logic [bez_pkg::CFG_W-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         bez_pkg::CSR_X1: cx1 = val;
         bez_pkg::CSR_X2: cx2 = val;
         bez_pkg::CSR_Y1: cy1 = val;
         bez_pkg::CSR_Y2: cy2 = val;
         default: tsize = val[12:0];
      endcase
   endtask

   task automatic set_curve(logic [16:0] x1, logic [16:0] x2, logic [16:0] y1,
                            logic [16:0] y2, logic [12:0] sz);
      write_csr(bez_pkg::CSR_X1, x1);
      write_csr(bez_pkg::CSR_X2, x2);
      write_csr(bez_pkg::CSR_Y1, y1);
      write_csr(bez_pkg::CSR_Y2, y2);
      write_csr(bez_pkg::CSR_SIZE, {4'd0, sz});
      csr_wen <= 1'b0;
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   task automatic send_entry(logic [12:0] idx, logic use_table, entry_result_type want);
      entry_result_type e;
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      e = use_table ? want : solve_entry(idx);
      pending_entries.push_back(e);
      req_valid <= 1'b1;
      req_entry_index <= idx;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL bezier_easing_table_entry_core");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) rsp_ready <= rsp_stalls ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      entry_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_entries.size() == 0) begin
            $display("%0t: unexpected word eased=%0d reason=%0d", $time,
                     rsp_eased_value, rsp_stop_reason);
            errors++;
         end else begin
            e = pending_entries.pop_front();
            if (rsp_eased_value !== e.eased) begin
               $display("%0t: eased_value expected %0d actual %0d", $time,
                        e.eased, rsp_eased_value);
               errors++;
            end
            if (rsp_stop_reason !== e.reason) begin
               $display("%0t: stop_reason expected %0d actual %0d", $time,
                        e.reason, rsp_stop_reason);
               errors++;
            end
         end
      end
   end

   typedef struct {
      logic [12:0] idx;
      logic use_table;
      entry_result_type want;
   } stim_row_type;

   stim_row_type dir_rows[$];

   function automatic stim_row_type row(logic [12:0] i, logic u, int ev);
      stim_row_type r;
      r.idx = i;
      r.use_table = u;
      r.want.eased = ev[bez_pkg::OUT_W-1:0];
      r.want.reason = bez_pkg::REASON_CONV;
      return r;
   endfunction

   initial begin
      int cfg;
      cx1 = 16384; cx2 = 49152; cy1 = 16384; cy2 = 49152; tsize = 256;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: indexes zero and one, middle and last entries, and indexes at or beyond the size.
      dir_rows = '{row(0, 0, 0), row(256, 1, 65536), row(257, 1, 65536),
                   row(8191, 1, 65536), row(4096, 1, 65536), row(128, 0, 0),
                   row(1, 0, 0), row(255, 0, 0), row(5461, 1, 65536)};
      foreach (dir_rows[k]) send_entry(dir_rows[k].idx, dir_rows[k].use_table,
                                       dir_rows[k].want);
      drain();

      // Extreme control points and sizes, flat slope, overshoot and size zero.
      set_curve(17'd0, 17'd0, 17'd0, 17'd0, 13'd1);
      send_entry(0, 0, '0); send_entry(1, 1, '{18'sd65536, bez_pkg::REASON_CONV});
      drain();
      set_curve(17'd65536, 17'd65536, 17'd65536, 17'd65536, 13'd4096);
      send_entry(1, 0, '0); send_entry(2048, 0, '0); send_entry(4095, 0, '0);
      drain();
      set_curve(17'h1ffff, 17'd0, 17'h1ffff, 17'd0, 13'd8191);
      send_entry(4000, 0, '0); send_entry(8190, 0, '0); send_entry(13, 0, '0);
      drain();
      set_curve(17'd0, 17'h1ffff, 17'd0, 17'h1ffff, 13'd7);
      send_entry(3, 0, '0); send_entry(6, 0, '0);
      drain();
      set_curve(17'd16384, 17'd49152, 17'd16384, 17'd49152, 13'd0);
      send_entry(0, 1, '{18'sd65536, bez_pkg::REASON_CONV});
      drain();

      for (cfg = 0; cfg < 10; cfg++) begin
         int pick;
         rsp_stalls = (cfg % 3) != 2;
         pick = $urandom_range(0, 3);
         set_curve(pick == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                   pick == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
                   17'($urandom), 17'($urandom_range(0, 65536)),
                   pick == 1 ? 13'($urandom) : 13'($urandom_range(1, 300)));
         repeat (70) begin
            logic [12:0] idx;
            if ($urandom_range(0, 9) == 0) idx = 13'($urandom);
            else idx = 13'($urandom_range(0, tsize));
            send_entry(idx, 0, '0);
         end
         drain();
      end

      if (errors == 0) begin
         $display("PASS bezier_easing_table_entry_core");
      end else begin
         $display("FAIL bezier_easing_table_entry_core");
      end
      $finish;
   end
endmodule
